>>> sv/upe_pkg.sv
// Shared types and constants for the UBX payload extractor.
package upe_pkg;

    // Width of the payload length and byte counters.
    localparam int LENGTH_BITS = 16;

    // Widths of the fixed fields.
    localparam int BYTE_BITS  = 8;
    localparam int FIELD_BITS = 16;

    // Frame sync bytes.
    localparam logic [BYTE_BITS-1:0] SYNC_FIRST  = 8'hB5;
    localparam logic [BYTE_BITS-1:0] SYNC_SECOND = 8'h62;

    // Configuration register indexes.
    localparam int CFG_INDEX_BITS = 1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WANTED_CLASS   = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WANTED_MESSAGE = 1'b1;

    // Configuration reset values.
    localparam logic [BYTE_BITS-1:0] WANTED_CLASS_RESET   = 8'd1;
    localparam logic [BYTE_BITS-1:0] WANTED_MESSAGE_RESET = 8'd7;

    // Parser phases.
    typedef enum logic [2:0] {
        PH_SYNC1   = 3'd0,
        PH_SYNC2   = 3'd1,
        PH_CLASS   = 3'd2,
        PH_MSG     = 3'd3,
        PH_LENLO   = 3'd4,
        PH_LENHI   = 3'd5,
        PH_PAYLOAD = 3'd6
    } phase_t;

    // One result from the parser to the output register.
    typedef struct packed {
        logic                  valid;
        logic [BYTE_BITS-1:0]  payload_byte;
        logic [FIELD_BITS-1:0] byte_index;
        logic [FIELD_BITS-1:0] frame_length;
        logic                  empty_frame;
        logic                  last;
    } result_t;

endpackage

>>> sv/upe_parser.sv
// Frame parser state machine: sync hunt, header match, length and payload count.
module upe_parser (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic [upe_pkg::BYTE_BITS-1:0] rx_byte,
    input  logic [upe_pkg::BYTE_BITS-1:0] wanted_class,
    input  logic [upe_pkg::BYTE_BITS-1:0] wanted_message,
    output upe_pkg::result_t              result
);
    import upe_pkg::*;

    phase_t                 phase_reg, phase_next;
    logic [LENGTH_BITS-1:0] exp_len_reg, exp_len_next;
    logic [LENGTH_BITS-1:0] count_reg, count_next;

    logic [FIELD_BITS-1:0]  header_len;
    logic [LENGTH_BITS-1:0] masked_len;
    logic [LENGTH_BITS-1:0] count_inc;
    logic                   final_byte;

    // Phase, length and count registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_SYNC1;
            exp_len_reg <= '0;
            count_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            exp_len_reg <= exp_len_next;
            count_reg   <= count_next;
        end
    end

    // Header length, low byte held from the previous step, masked to the counter width.
    assign header_len = {rx_byte, exp_len_reg[BYTE_BITS-1:0]};
    assign masked_len = header_len[LENGTH_BITS-1:0];
    assign count_inc  = count_reg + LENGTH_BITS'(1);
    assign final_byte = (count_inc == exp_len_reg);

    // Next phase and result for the byte in hand.
    always_comb
    begin
        phase_next   = PH_SYNC1;
        exp_len_next = exp_len_reg;
        count_next   = count_reg;
        result       = '0;
        case (phase_reg)
            PH_SYNC1:
            begin
                phase_next = (rx_byte == SYNC_FIRST) ? PH_SYNC2 : PH_SYNC1;
            end
            PH_SYNC2:
            begin
                phase_next = (rx_byte == SYNC_SECOND) ? PH_CLASS : PH_SYNC1;
            end
            PH_CLASS:
            begin
                phase_next = (rx_byte == wanted_class) ? PH_MSG : PH_SYNC1;
            end
            PH_MSG:
            begin
                phase_next = (rx_byte == wanted_message) ? PH_LENLO : PH_SYNC1;
            end
            PH_LENLO:
            begin
                exp_len_next = LENGTH_BITS'(rx_byte);
                phase_next   = PH_LENHI;
            end
            PH_LENHI:
            begin
                exp_len_next = masked_len;
                count_next   = '0;
                if (masked_len == '0)
                begin
                    // Empty frame: one result carrying no byte.
                    result.valid       = 1'b1;
                    result.empty_frame = 1'b1;
                    result.last        = 1'b1;
                    phase_next         = PH_SYNC1;
                end
                else
                begin
                    phase_next = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                result.valid        = 1'b1;
                result.payload_byte = rx_byte;
                result.byte_index   = FIELD_BITS'(count_reg);
                result.frame_length = FIELD_BITS'(exp_len_reg);
                result.last         = final_byte;
                if (final_byte)
                begin
                    count_next = '0;
                    phase_next = PH_SYNC1;
                end
                else
                begin
                    count_next = count_inc;
                    phase_next = PH_PAYLOAD;
                end
            end
            default:
            begin
                phase_next = PH_SYNC1;
            end
        endcase
    end

endmodule

>>> sv/ubx_payload_extractor.sv
// Top level of the UBX payload extractor: config registers, input and output stages.
// Path: a byte's transfer loads the input register; the result register takes the byte's
// result from the parser when the held byte moves on; a stalled output can hold that back.
// Throughput: one byte per cycle unless the output stalls; the parser steps once per byte.
// Reset clears the parser to the sync hunt, empties both stages and sets the wanted
// class to 1 and the wanted message to 7.
module ubx_payload_extractor (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [upe_pkg::BYTE_BITS-1:0]      rx_byte,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [upe_pkg::BYTE_BITS-1:0]      payload_byte,
    output logic [upe_pkg::FIELD_BITS-1:0]     byte_index,
    output logic [upe_pkg::FIELD_BITS-1:0]     frame_length,
    output logic                               empty_frame,
    output logic                               last,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [upe_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [upe_pkg::BYTE_BITS-1:0]      cfg_data
);
    import upe_pkg::*;

    logic [BYTE_BITS-1:0] wanted_class_reg;
    logic [BYTE_BITS-1:0] wanted_message_reg;
    logic                 in_vld_reg;
    logic [BYTE_BITS-1:0] in_byte_reg;
    logic                 out_vld_reg;
    result_t              out_res_reg;
    result_t              parse_res;
    logic                 advance;
    logic                 in_accept;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wanted_class_reg   <= WANTED_CLASS_RESET;
            wanted_message_reg <= WANTED_MESSAGE_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_WANTED_CLASS:   wanted_class_reg   <= cfg_data;
                REG_WANTED_MESSAGE: wanted_message_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    // The held byte moves on when the result register is empty or being drained.
    assign advance   = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall  = in_vld_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    upe_parser u_parser (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (advance),
        .rx_byte        (in_byte_reg),
        .wanted_class   (wanted_class_reg),
        .wanted_message (wanted_message_reg),
        .result         (parse_res)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= parse_res.valid;
        end
        else if (!out_stall)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_res_reg <= parse_res;
        end
    end

    assign out_valid    = out_vld_reg;
    assign payload_byte = out_res_reg.payload_byte;
    assign byte_index   = out_res_reg.byte_index;
    assign frame_length = out_res_reg.frame_length;
    assign empty_frame  = out_res_reg.empty_frame;
    assign last         = out_res_reg.last;

endmodule

>>> sv/upe_checker.sv
// Port-level assertions for the UBX payload extractor and their bind.
module upe_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_stall,
    input logic                               out_valid,
    input logic                               out_stall,
    input logic [upe_pkg::BYTE_BITS-1:0]      payload_byte,
    input logic [upe_pkg::FIELD_BITS-1:0]     byte_index,
    input logic [upe_pkg::FIELD_BITS-1:0]     frame_length,
    input logic                               empty_frame,
    input logic                               last
);
    import upe_pkg::*;

    // A stalled result holds until its transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(payload_byte)
            && $stable(byte_index) && $stable(last))
        else $error("stalled result changed");

    // An empty frame result is a single all-zero final result.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && empty_frame |-> last && payload_byte == '0
            && byte_index == '0 && frame_length == '0)
        else $error("malformed empty frame result");

    // A payload byte index stays below the frame length.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !empty_frame |-> byte_index < frame_length)
        else $error("byte index beyond frame length");

    // The final payload byte is the one at length minus one.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !empty_frame && last |-> FIELD_BITS'(byte_index + 1'b1) == frame_length)
        else $error("last flag on the wrong byte");

    // Input is held back only while a result waits on a stalled output.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output backpressure");

endmodule

bind ubx_payload_extractor upe_checker u_upe_checker (.*);

>>> sim/tb_ubx_payload_extractor.sv
// Self-checking testbench for the UBX payload extractor.
`timescale 1ns / 1ps

module tb_ubx_payload_extractor;
    import upe_pkg::*;

    localparam int          HALF_PERIOD        = 2;
    localparam int          RESET_CYCLES       = 8;
    localparam int          DRAIN_CYCLES       = 8;
    localparam int unsigned HOLD_CYCLES        = 300;
    localparam int unsigned QUIET_LIMIT        = 2000;
    localparam int unsigned RANDOM_FRAME_BYTES = 360;

    // Length mask for the width of the block's counters.
    localparam logic [FIELD_BITS-1:0] LEN_MASK =
        FIELD_BITS'((32'd1 << LENGTH_BITS) - 32'd1);

    // One expected payload result.
    typedef struct {
        logic [BYTE_BITS-1:0]  data;
        logic [FIELD_BITS-1:0] index;
        logic [FIELD_BITS-1:0] length;
        logic                  empty;
        logic                  last;
    } payload_rec_t;

    logic                      clk          = 1'b0;
    logic                      rst_n        = 1'b0;
    logic                      in_valid     = 1'b0;
    logic                      in_stall;
    logic [BYTE_BITS-1:0]      rx_byte      = '0;
    logic                      out_valid;
    logic                      out_stall    = 1'b0;
    logic [BYTE_BITS-1:0]      payload_byte;
    logic [FIELD_BITS-1:0]     byte_index;
    logic [FIELD_BITS-1:0]     frame_length;
    logic                      empty_frame;
    logic                      last;
    logic                      cfg_valid    = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index    = '0;
    logic [BYTE_BITS-1:0]      cfg_data     = '0;

    // Parser state as the testbench tracks it.
    phase_t                parse_ph    = PH_SYNC1;
    logic [FIELD_BITS-1:0] hdr_len     = '0;
    logic [FIELD_BITS-1:0] pay_count   = '0;
    logic [BYTE_BITS-1:0]  match_class = WANTED_CLASS_RESET;
    logic [BYTE_BITS-1:0]  match_msg   = WANTED_MESSAGE_RESET;

    payload_rec_t expected_payloads[$];

    int unsigned gap_ahead      = 0;
    int unsigned hold_len       = 0;
    bit          sender_quiet   = 1'b0;
    bit          receiver_quiet = 1'b0;
    int unsigned n_bytes        = 0;
    int unsigned n_results      = 0;
    int unsigned n_frames       = 0;
    int unsigned n_empty        = 0;
    int unsigned n_reg_writes   = 0;
    int unsigned n_errors       = 0;

    ubx_payload_extractor i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .payload_byte (payload_byte),
        .byte_index   (byte_index),
        .frame_length (frame_length),
        .empty_frame  (empty_frame),
        .last         (last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // Step the parser by one received byte and queue any payload result it yields.
    function automatic void parse_rx_byte(input logic [BYTE_BITS-1:0] b);
        payload_rec_t          rec;
        logic [FIELD_BITS-1:0] idx;
        logic [FIELD_BITS-1:0] nxt;
        case (parse_ph)
            PH_SYNC1: parse_ph = (b == SYNC_FIRST) ? PH_SYNC2 : PH_SYNC1;
            PH_SYNC2: parse_ph = (b == SYNC_SECOND) ? PH_CLASS : PH_SYNC1;
            PH_CLASS: parse_ph = (b == match_class) ? PH_MSG : PH_SYNC1;
            PH_MSG:   parse_ph = (b == match_msg) ? PH_LENLO : PH_SYNC1;
            PH_LENLO:
            begin
                hdr_len  = {8'h00, b};
                parse_ph = PH_LENHI;
            end
            PH_LENHI:
            begin
                hdr_len   = {b, hdr_len[7:0]} & LEN_MASK;
                pay_count = '0;
                if (hdr_len == '0)
                begin
                    rec = '{data: '0, index: '0, length: '0, empty: 1'b1, last: 1'b1};
                    expected_payloads.push_back(rec);
                    parse_ph = PH_SYNC1;
                end
                else
                begin
                    parse_ph = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                idx = pay_count & LEN_MASK;
                nxt = (idx + 1'b1) & LEN_MASK;
                rec = '{data: b, index: idx, length: hdr_len, empty: 1'b0,
                        last: (nxt == (hdr_len & LEN_MASK))};
                expected_payloads.push_back(rec);
                if (rec.last)
                begin
                    pay_count = '0;
                    parse_ph  = PH_SYNC1;
                end
                else
                begin
                    pay_count = nxt;
                end
            end
            default: parse_ph = PH_SYNC1;
        endcase
    endfunction

    // Sender gap: mostly none, some short, a few long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (sender_quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Receiver stall run: mostly none, some short, a few long.
    function automatic int unsigned pick_stall();
        int unsigned r;
        if (receiver_quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Payload length: mostly short, some empty, rarely past one byte of length.
    function automatic logic [FIELD_BITS-1:0] pick_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return '0;
        else if (r < 16)
            return 16'd1;
        else if (r < 88)
            return FIELD_BITS'($urandom_range(2, 12));
        else if (r < 99)
            return FIELD_BITS'($urandom_range(13, 48));
        return FIELD_BITS'($urandom_range(256, 270));
    endfunction

    function automatic void check_field(input string name, input logic [FIELD_BITS-1:0] want,
                                        input logic [FIELD_BITS-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
            n_errors++;
        end
    endfunction

    // Offer one byte and wait for its transfer; the valid stays up if the next gap is zero.
    task automatic send_byte(input logic [BYTE_BITS-1:0] b);
        repeat (gap_ahead) @(posedge clk);
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        parse_rx_byte(b);
        n_bytes++;
        gap_ahead = pick_gap();
        if (gap_ahead != 0)
            in_valid <= 1'b0;
    endtask

    task automatic pause_sender();
        if (gap_ahead == 0)
            in_valid <= 1'b0;
    endtask

    // Stop sending, let every expected result arrive, then let the pipeline empty.
    task automatic wait_idle();
        pause_sender();
        while (expected_payloads.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write both wanted ids back to back with the valid held high.
    task automatic configure(input logic [BYTE_BITS-1:0] cls, input logic [BYTE_BITS-1:0] msg);
        cfg_valid <= 1'b1;
        cfg_index <= REG_WANTED_CLASS;
        cfg_data  <= cls;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        cfg_index <= REG_WANTED_MESSAGE;
        cfg_data  <= msg;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        match_class  = cls;
        match_msg    = msg;
        n_reg_writes += 2;
    endtask

    task automatic send_header(input logic [BYTE_BITS-1:0] cls, input logic [BYTE_BITS-1:0] msg,
                               input logic [FIELD_BITS-1:0] len);
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        send_byte(cls);
        send_byte(msg);
        send_byte(len[7:0]);
        send_byte(len[15:8]);
    endtask

    // A whole frame with random payload and two random checksum bytes.
    task automatic send_frame(input logic [BYTE_BITS-1:0] cls, input logic [BYTE_BITS-1:0] msg,
                              input logic [FIELD_BITS-1:0] len);
        send_header(cls, msg, len);
        repeat (len) send_byte(BYTE_BITS'($urandom));
        repeat (2) send_byte(BYTE_BITS'($urandom));
    endtask

    // A header that goes wrong at the second sync byte, the class or the message id.
    task automatic send_broken_header();
        logic [BYTE_BITS-1:0] hdr [0:3];
        int unsigned          bad_pos;
        hdr     = '{SYNC_FIRST, SYNC_SECOND, match_class, match_msg};
        bad_pos = $urandom_range(1, 3);
        for (int i = 0; i < bad_pos; i++)
            send_byte(hdr[2'(i)]);
        send_byte(hdr[2'(bad_pos)] ^ BYTE_BITS'($urandom_range(1, 255)));
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 8))
        begin
            if ($urandom_range(0, 4) == 0)
                send_byte(SYNC_FIRST);
            else
                send_byte(BYTE_BITS'($urandom));
        end
    endtask

    // Frames under the reset ids, sync restart inside checksum bytes, header rejections.
    task automatic test_directed_headers();
        send_header(WANTED_CLASS_RESET, WANTED_MESSAGE_RESET, 16'd2);
        send_byte(8'h00);
        send_byte(8'hFF);
        // Checksum bytes that read as sync bytes start a new frame, here an empty one.
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        send_byte(WANTED_CLASS_RESET);
        send_byte(WANTED_MESSAGE_RESET);
        send_byte(8'h00);
        send_byte(8'h00);
        // Wrong second sync byte, wrong class, wrong message id.
        send_byte(SYNC_FIRST);
        send_byte(8'h63);
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        send_byte(WANTED_CLASS_RESET + 8'd1);
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        send_byte(WANTED_CLASS_RESET);
        send_byte(WANTED_MESSAGE_RESET - 8'd1);
    endtask

    // One id setting: matching frames, frames with a wrong class or message, an empty frame.
    task automatic try_setting(input logic [BYTE_BITS-1:0] cls, input logic [BYTE_BITS-1:0] msg);
        wait_idle();
        configure(cls, msg);
        send_frame(cls, msg, FIELD_BITS'($urandom_range(1, 4)));
        send_frame(cls ^ 8'h01, msg, 16'd3);
        send_frame(cls, ~msg, 16'd2);
        send_frame(cls, msg, 16'd0);
    endtask

    task automatic test_register_settings();
        try_setting(8'h00, 8'h00);
        try_setting(8'hFF, 8'hFF);
        try_setting(8'h00, 8'hFF);
        try_setting(8'hFF, 8'h00);
        try_setting(SYNC_FIRST, SYNC_SECOND);
        try_setting(BYTE_BITS'($urandom), BYTE_BITS'($urandom));
    endtask

    // The receiver holds off while the sender keeps offering, so the input backs up.
    task automatic test_output_backpressure();
        wait_idle();
        sender_quiet = 1'b1;
        hold_len     = HOLD_CYCLES;
        send_frame(match_class, match_msg, 16'd40);
        sender_quiet = 1'b0;
    endtask

    // The sender stops in the middle of a payload until all results are out.
    task automatic test_sender_pause();
        wait_idle();
        send_header(match_class, match_msg, 16'd10);
        repeat (5) send_byte(BYTE_BITS'($urandom));
        wait_idle();
        repeat (5) send_byte(BYTE_BITS'($urandom));
        repeat (2) send_byte(BYTE_BITS'($urandom));
    endtask

    // A frame whose length uses both header bytes, with both sides running flat out.
    task automatic test_longest_frame();
        wait_idle();
        sender_quiet   = 1'b1;
        receiver_quiet = 1'b1;
        send_frame(match_class, match_msg, 16'd300);
        sender_quiet   = 1'b0;
        receiver_quiet = 1'b0;
    endtask

    // Mostly well-formed frames, with broken headers, noise and id changes mixed in.
    task automatic test_random_stream();
        int unsigned           frame_bytes;
        int unsigned           pick;
        logic [FIELD_BITS-1:0] len;
        frame_bytes = 0;
        while (frame_bytes < RANDOM_FRAME_BYTES)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 3)
            begin
                wait_idle();
                if ($urandom_range(0, 1) == 0)
                    configure(WANTED_CLASS_RESET, WANTED_MESSAGE_RESET);
                else
                    configure(BYTE_BITS'($urandom), BYTE_BITS'($urandom));
            end
            else if (pick < 75)
            begin
                // An occasional frame with no idling on either side.
                sender_quiet   = ($urandom_range(0, 9) == 0);
                receiver_quiet = sender_quiet;
                len = pick_length();
                send_frame(match_class, match_msg, len);
                frame_bytes += len + 8;
                sender_quiet   = 1'b0;
                receiver_quiet = 1'b0;
            end
            else if (pick < 88)
            begin
                send_broken_header();
            end
            else
            begin
                send_noise();
            end
        end
    endtask

    // Receiver: ready runs broken by stall runs, or one long hold on request.
    initial
    begin : receiver
        int unsigned ready_run;
        int unsigned stall_run;
        wait (rst_n === 1'b1);
        forever
        begin
            ready_run = $urandom_range(1, 8);
            repeat (ready_run)
            begin
                @(posedge clk);
                if (hold_len != 0)
                    break;
            end
            if (hold_len != 0)
            begin
                stall_run = hold_len;
                hold_len  = 0;
            end
            else
            begin
                stall_run = pick_stall();
            end
            if (stall_run != 0)
            begin
                out_stall <= 1'b1;
                repeat (stall_run) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Compare each result transfer with the oldest expectation.
    always @(posedge clk)
    begin : check_payload_out
        payload_rec_t want;
        if (rst_n && out_valid === 1'b1 && out_stall == 1'b0)
        begin
            if (expected_payloads.size() == 0)
            begin
                $display("%0t: result with none expected: byte 0x%0h index %0d length %0d",
                         $time, payload_byte, byte_index, frame_length);
                n_errors++;
            end
            else
            begin
                want = expected_payloads.pop_front();
                check_field("payload_byte", FIELD_BITS'(want.data), FIELD_BITS'(payload_byte));
                check_field("byte_index", want.index, byte_index);
                check_field("frame_length", want.length, frame_length);
                check_field("empty_frame", FIELD_BITS'(want.empty), FIELD_BITS'(empty_frame));
                check_field("last", FIELD_BITS'(want.last), FIELD_BITS'(last));
                n_results++;
                if (want.last)
                    n_frames++;
                if (want.empty)
                    n_empty++;
            end
        end
    end

    // Watchdog: end the run when no transfer happens on any channel for too long.
    initial
    begin : watchdog
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_stall == 1'b0) ||
                (out_valid === 1'b1 && !out_stall) || (cfg_valid && cfg_ready === 1'b1))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                 $time, QUIET_LIMIT, expected_payloads.size());
        $display("Mismatches found");
        $finish;
    end

    // Test sequence.
    initial
    begin : main_sequence
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_headers();
        test_register_settings();
        test_output_backpressure();
        test_sender_pause();
        test_longest_frame();
        test_random_stream();
        wait_idle();
        $display("Sent %0d bytes; checked %0d payload results in %0d frames (%0d empty).",
                 n_bytes, n_results, n_frames, n_empty);
        $display("Made %0d register writes, including all-zero and all-one ids.",
                 n_reg_writes);
        if (n_errors == 0 && expected_payloads.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
